// ----- rtl/sorted_interval_set_table_top_assert.svh -----
// Assertion macros shared by the interval set table modules.
`ifndef SORTED_INTERVAL_SET_TABLE_TOP_ASSERT_SVH
`define SORTED_INTERVAL_SET_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SIST_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sist assertion failed");

// Next-cycle implication.
`define SIST_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sist assertion failed");

`endif

// ----- rtl/sist_pkg.sv -----
// Types and constants of the interval set table.
package sist_pkg;

   localparam int MaxRanges = 64;
   localparam int IdxW      = $clog2(MaxRanges);
   localparam int CntW      = $clog2(MaxRanges + 1);
   localparam int NW        = $clog2(MaxRanges + 2);
   localparam int EntryW    = 128;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_INC   = 3'd2;
   localparam logic [2:0] OP_CLEAR = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_INDEX   = 2'd3;

   localparam logic signed [63:0] LlongMin = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] LlongMax = 64'sh7fff_ffff_ffff_ffff;

   typedef enum logic [2:0] {
      K_ADD, K_SUB, K_INC, K_CLEAR, K_READ, K_NOP, K_BAD
   } kind_type;

   typedef struct packed {
      logic [2:0]        operation;
      logic signed [63:0] range_low;
      logic signed [63:0] range_high;
      logic [5:0]        entry_index;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic              included;
      logic [6:0]        entry_count;
      logic signed [63:0] entry_low;
      logic signed [63:0] entry_high;
   } rsp_type;

   typedef struct packed {
      kind_type          kind;
      logic signed [63:0] range_low;
      logic signed [63:0] range_high;
      logic [5:0]        entry_index;
   } cmd_type;

endpackage

// ----- rtl/sorted_interval_set_table_top.sv -----
// Top level of the sorted interval set table.
//
//   channel   ports                      accepted when
//   request   start, busy, req_item      start high and busy low at a clock edge
//   result    rsp_strobe, rsp_item       every edge that ends a cycle with rsp_strobe high
//
// Items wait in a two-entry queue; busy is high while it is full.
// Add makes a scan pass, then a rebuild pass, over the N stored ranges, reading each
// entry through the registered RAM read, with an extra write state per merged insert.
// Subtract and includes make one pass; subtract adds a write state per split.
// The result is registered; the receiver cannot stall it.
// Synchronous reset empties the table at once; no clearing pass is needed.
module sorted_interval_set_table_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sist_pkg::req_type req_item,
   output logic              rsp_strobe,
   output sist_pkg::rsp_type rsp_item
);
   import sist_pkg::*;

   logic    cmd_valid, cmd_pop;
   cmd_type cmd;

   sist_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   sist_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

// ----- rtl/sist_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sist_ram #(
   parameter int Width = 128,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rdata_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rdata_ff;

endmodule

// ----- rtl/sist_front.sv -----
// Request intake: classifies each item and queues it for the back end.
`include "sorted_interval_set_table_top_assert.svh"
module sist_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sist_pkg::req_type req_item,
   output logic              cmd_valid,
   output sist_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import sist_pkg::*;

   cmd_type    q_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   cmd_type    cmd_new;

   assign busy = (cnt_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      cmd_new.range_low   = req_item.range_low;
      cmd_new.range_high  = req_item.range_high;
      cmd_new.entry_index = req_item.entry_index;
      unique case (req_item.operation)
         OP_ADD:   cmd_new.kind = K_ADD;
         OP_SUB:   cmd_new.kind = K_SUB;
         OP_INC:   cmd_new.kind = K_INC;
         OP_CLEAR: cmd_new.kind = K_CLEAR;
         OP_READ:  cmd_new.kind = K_READ;
         default:  cmd_new.kind = K_NOP;
      endcase
      // reversed range on a range operation is rejected up front
      if ((req_item.operation == OP_ADD || req_item.operation == OP_SUB ||
           req_item.operation == OP_INC) && req_item.range_low > req_item.range_high) begin
         cmd_new.kind = K_BAD;
      end
   end

   always_comb begin
      case ({push, cmd_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wp_ff <= ~wp_ff;
         end
         if (cmd_pop) begin
            rp_ff <= ~rp_ff;
         end
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   `SIST_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_ff <= 2'd2)
   `SIST_ASSERT_NEXT(a_fifo_push, push && !cmd_pop, cnt_ff == $past(cnt_ff) + 2'd1)

endmodule

// ----- rtl/sist_back.sv -----
// Table engine: walks the stored ranges; add and subtract rebuild them into the spare bank.
`include "sorted_interval_set_table_top_assert.svh"
module sist_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  sist_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_strobe,
   output sist_pkg::rsp_type rsp_item
);
   import sist_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_RD, S_EV, S_WR2, S_FIN, S_RDX} state_type;

   state_type          state_ff, state_in;
   kind_type           kind_ff, kind_in;
   logic signed [63:0] lo_ff, lo_in, hi_ff, hi_in;
   logic signed [63:0] nl_ff, nl_in, nh_ff, nh_in;
   logic signed [63:0] pl_ff, pl_in, ph_ff, ph_in;
   logic [CntW-1:0]    count_ff, count_in, i_ff, i_in;
   logic [NW-1:0]      n_ff, n_in;
   logic               bank_ff, bank_in, pass_ff, pass_in;
   logic               placed_ff, placed_in, inc_ff, inc_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;

   logic               wr_req, ram_we;
   logic [EntryW-1:0]  wr_data;
   logic [IdxW-1:0]    raddr;
   logic [EntryW-1:0]  rd0, rd1, rdata;
   logic signed [63:0] l_cur, h_cur;
   logic               touch, outside;

   assign rdata = bank_ff ? rd1 : rd0;
   assign l_cur = rdata[127:64];
   assign h_cur = rdata[63:0];

   assign touch = !(((lo_ff != LlongMin) && (h_cur < lo_ff - 64'sd1)) ||
                    ((hi_ff != LlongMax) && (l_cur > hi_ff + 64'sd1)));
   assign outside = (h_cur < lo_ff) || (l_cur > hi_ff);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      nl_in     = nl_ff;
      nh_in     = nh_ff;
      pl_in     = pl_ff;
      ph_in     = ph_ff;
      count_in  = count_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      bank_in   = bank_ff;
      pass_in   = pass_ff;
      placed_in = placed_ff;
      inc_in    = inc_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      wr_req    = 1'b0;
      wr_data   = '0;
      raddr     = i_ff[IdxW-1:0];
      cmd_pop   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            raddr = IdxW'(cmd.entry_index);
            if (cmd_valid) begin
               cmd_pop          = 1'b1;
               kind_in          = cmd.kind;
               lo_in            = cmd.range_low;
               hi_in            = cmd.range_high;
               nl_in            = cmd.range_low;
               nh_in            = cmd.range_high;
               i_in             = '0;
               n_in             = '0;
               pass_in          = 1'b0;
               placed_in        = 1'b0;
               inc_in           = 1'b0;
               rsp_in.status    = ST_OK;
               rsp_in.included  = 1'b0;
               rsp_in.entry_low  = '0;
               rsp_in.entry_high = '0;
               unique case (cmd.kind)
                  K_ADD, K_SUB, K_INC: state_in = S_RD;
                  K_READ: begin
                     if (32'(cmd.entry_index) < 32'(count_ff)) begin
                        state_in = S_RDX;
                     end else begin
                        rsp_in.status = ST_INDEX;
                        strobe_in     = 1'b1;
                     end
                  end
                  K_CLEAR: begin
                     count_in  = '0;
                     strobe_in = 1'b1;
                  end
                  K_BAD: begin
                     rsp_in.status = ST_INVALID;
                     strobe_in     = 1'b1;
                  end
                  default: strobe_in = 1'b1;
               endcase
               rsp_in.entry_count = 7'(count_in);
            end
         end
         S_RD: begin
            if (i_ff == count_ff) begin
               if (kind_ff == K_ADD && !pass_ff) begin
                  pass_in = 1'b1;
                  i_in    = '0;
               end else begin
                  if (kind_ff == K_ADD && !placed_ff) begin
                     wr_req  = 1'b1;
                     wr_data = {nl_ff, nh_ff};
                  end
                  state_in = S_FIN;
               end
            end else begin
               state_in = S_EV;
            end
         end
         S_EV: begin
            i_in     = i_ff + 1'b1;
            state_in = S_RD;
            case (kind_ff)
               K_ADD: begin
                  if (!pass_ff) begin
                     if (touch) begin
                        if (l_cur < nl_ff) nl_in = l_cur;
                        if (h_cur > nh_ff) nh_in = h_cur;
                     end
                  end else if (!touch) begin
                     if (h_cur >= nl_ff && !placed_ff) begin
                        wr_req    = 1'b1;
                        wr_data   = {nl_ff, nh_ff};
                        placed_in = 1'b1;
                        pl_in     = l_cur;
                        ph_in     = h_cur;
                        state_in  = S_WR2;
                     end else begin
                        wr_req  = 1'b1;
                        wr_data = {l_cur, h_cur};
                     end
                  end
               end
               K_SUB: begin
                  if (outside) begin
                     wr_req  = 1'b1;
                     wr_data = {l_cur, h_cur};
                  end else if (l_cur < lo_ff) begin
                     wr_req  = 1'b1;
                     wr_data = {l_cur, lo_ff - 64'sd1};
                     if (h_cur > hi_ff) begin
                        // split: upper piece follows next cycle
                        pl_in    = hi_ff + 64'sd1;
                        ph_in    = h_cur;
                        state_in = S_WR2;
                     end
                  end else if (h_cur > hi_ff) begin
                     wr_req  = 1'b1;
                     wr_data = {hi_ff + 64'sd1, h_cur};
                  end
               end
               K_INC: begin
                  if (l_cur <= lo_ff && h_cur >= hi_ff) inc_in = 1'b1;
               end
               default: ;
            endcase
         end
         S_WR2: begin
            wr_req   = 1'b1;
            wr_data  = {pl_ff, ph_ff};
            state_in = S_RD;
         end
         S_FIN: begin
            rsp_in.included = inc_ff;
            if (kind_ff == K_ADD || kind_ff == K_SUB) begin
               if (n_ff > NW'(MaxRanges)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  count_in = CntW'(n_ff);
                  bank_in  = ~bank_ff;
               end
            end
            rsp_in.entry_count = 7'(count_in);
            strobe_in          = 1'b1;
            state_in           = S_IDLE;
         end
         S_RDX: begin
            rsp_in.entry_low   = l_cur;
            rsp_in.entry_high  = h_cur;
            rsp_in.entry_count = 7'(count_ff);
            strobe_in          = 1'b1;
            state_in           = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      // pieces past capacity are only counted
      if (wr_req && n_ff <= NW'(MaxRanges)) begin
         n_in = n_ff + 1'b1;
      end
   end

   assign ram_we = wr_req && (n_ff < NW'(MaxRanges));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         bank_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         bank_ff   <= bank_in;
         strobe_ff <= strobe_in;
      end
      kind_ff   <= kind_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      nl_ff     <= nl_in;
      nh_ff     <= nh_in;
      pl_ff     <= pl_in;
      ph_ff     <= ph_in;
      i_ff      <= i_in;
      n_ff      <= n_in;
      pass_ff   <= pass_in;
      placed_ff <= placed_in;
      inc_ff    <= inc_in;
      rsp_ff    <= rsp_in;
   end

   sist_ram #(.Width(EntryW), .Depth(MaxRanges)) u_bank0 (
      .clock   (clock),
      .wr_en   (ram_we && bank_ff),
      .wr_addr (n_ff[IdxW-1:0]),
      .wr_data (wr_data),
      .rd_addr (raddr),
      .rd_data (rd0)
   );

   sist_ram #(.Width(EntryW), .Depth(MaxRanges)) u_bank1 (
      .clock   (clock),
      .wr_en   (ram_we && !bank_ff),
      .wr_addr (n_ff[IdxW-1:0]),
      .wr_data (wr_data),
      .rd_addr (raddr),
      .rd_data (rd1)
   );

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

   `SIST_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CntW'(MaxRanges))
   `SIST_ASSERT_IMP(a_wr_capacity, ram_we, n_ff < NW'(MaxRanges))
   `SIST_ASSERT_IMP(a_wr2_order, state_ff == S_WR2, $past(state_ff) == S_EV)
   `SIST_ASSERT_IMP(a_rsp_source, rsp_strobe,
      $past(state_ff) == S_IDLE || $past(state_ff) == S_FIN || $past(state_ff) == S_RDX)

endmodule

// ----- tb/sorted_interval_set_table_top_tb.sv -----
// Self-checking testbench for the sorted interval set table: directed and random requests.
`timescale 1ns / 100ps

module sorted_interval_set_table_top_tb;
   import sist_pkg::*;

   localparam int TableDepth   = 64;
   localparam int IdleLimit    = 20000;
   localparam int RandomItems  = 1700;

   // Holds the interval table image and the queue of predicted responses.
   class interval_scoreboard;
      logic signed [63:0] low_ends[TableDepth];
      logic signed [63:0] high_ends[TableDepth];
      int unsigned        count;
      rsp_type            pending[$];
      int unsigned        errors;

      function void clear_table();
         count = 0;
      endfunction

      function bit adjoins(logic signed [63:0] l, logic signed [63:0] h,
                           logic signed [63:0] lo, logic signed [63:0] hi);
         if (lo != LlongMin && h < lo - 64'sd1) return 0;
         if (hi != LlongMax && l > hi + 64'sd1) return 0;
         return 1;
      endfunction

      function logic [1:0] store_pieces(logic signed [63:0] pl[$], logic signed [63:0] ph[$]);
         if (pl.size() > TableDepth) return ST_FULL;
         foreach (pl[i]) begin
            low_ends[i]  = pl[i];
            high_ends[i] = ph[i];
         end
         count = pl.size();
         return ST_OK;
      endfunction

      function logic [1:0] merge_range(logic signed [63:0] lo, logic signed [63:0] hi);
         logic signed [63:0] nl, nh;
         logic signed [63:0] pl[$], ph[$];
         bit placed;
         nl = lo;
         nh = hi;
         placed = 0;
         for (int i = 0; i < count; i++)
            if (adjoins(low_ends[i], high_ends[i], lo, hi)) begin
               if (low_ends[i] < nl) nl = low_ends[i];
               if (high_ends[i] > nh) nh = high_ends[i];
            end
         for (int i = 0; i < count; i++) begin
            if (adjoins(low_ends[i], high_ends[i], lo, hi)) continue;
            if (high_ends[i] >= nl && !placed) begin
               pl = {pl, nl};
               ph = {ph, nh};
               placed = 1;
            end
            pl = {pl, low_ends[i]};
            ph = {ph, high_ends[i]};
         end
         if (!placed) begin
            pl = {pl, nl};
            ph = {ph, nh};
         end
         return store_pieces(pl, ph);
      endfunction

      function logic [1:0] cut_range(logic signed [63:0] lo, logic signed [63:0] hi);
         logic signed [63:0] pl[$], ph[$];
         for (int i = 0; i < count; i++) begin
            if (high_ends[i] < lo || low_ends[i] > hi) begin
               pl = {pl, low_ends[i]};
               ph = {ph, high_ends[i]};
               continue;
            end
            if (low_ends[i] < lo) begin
               pl = {pl, low_ends[i]};
               ph = {ph, lo - 64'sd1};
            end
            if (high_ends[i] > hi) begin
               pl = {pl, hi + 64'sd1};
               ph = {ph, high_ends[i]};
            end
         end
         return store_pieces(pl, ph);
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         e = '0;
         if (r.operation <= OP_INC && r.range_low > r.range_high)
            e.status = ST_INVALID;
         else if (r.operation == OP_ADD)
            e.status = merge_range(r.range_low, r.range_high);
         else if (r.operation == OP_SUB)
            e.status = cut_range(r.range_low, r.range_high);
         else if (r.operation == OP_INC) begin
            for (int i = 0; i < count; i++)
               if (low_ends[i] <= r.range_low && high_ends[i] >= r.range_high)
                  e.included = 1'b1;
         end else if (r.operation == OP_CLEAR)
            count = 0;
         else if (r.operation == OP_READ) begin
            if (r.entry_index < count) begin
               e.entry_low  = low_ends[r.entry_index];
               e.entry_high = high_ends[r.entry_index];
            end else
               e.status = ST_INDEX;
         end
         e.entry_count = count[6:0];
         pending = {pending, e};
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: response with none expected, actual %p", $realtime, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
            errors++;
         end
         if (a.included !== e.included) begin
            $display("%0t: included expected %0d actual %0d", $realtime, e.included,
                     a.included);
            errors++;
         end
         if (a.entry_count !== e.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $realtime, e.entry_count,
                     a.entry_count);
            errors++;
         end
         if (a.entry_low !== e.entry_low) begin
            $display("%0t: entry_low expected %h actual %h", $realtime, e.entry_low,
                     a.entry_low);
            errors++;
         end
         if (a.entry_high !== e.entry_high) begin
            $display("%0t: entry_high expected %h actual %h", $realtime, e.entry_high,
                     a.entry_high);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_strobe;
   rsp_type rsp_item;

   interval_scoreboard table_model;
   int unsigned        idle_cycles;
   logic signed [63:0] anchor;

   sorted_interval_set_table_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) table_model.check_response(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("sorted_interval_set_table_top: mismatch");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Drives one item and holds start until it is taken.
   task automatic send_item(logic [2:0] op, logic signed [63:0] lo, logic signed [63:0] hi,
                            logic [5:0] idx, bit no_gap);
      req_type r;
      int unsigned gap;
      r.operation   = op;
      r.range_low   = lo;
      r.range_high  = hi;
      r.entry_index = idx;
      gap = no_gap ? 0 : pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      table_model.note_request(r);
   endtask

   function automatic logic signed [63:0] near_value();
      case ($urandom_range(0, 9))
         0: return LlongMin + $urandom_range(0, 40);
         1: return LlongMax - $urandom_range(0, 40);
         2: return {$urandom, $urandom};
         default: return anchor + $signed(64'($urandom_range(0, 400)));
      endcase
   endfunction

   task automatic random_item(bit no_gap);
      logic signed [63:0] a, b, t;
      logic [2:0] op;
      int unsigned sel;
      a = near_value();
      b = ($urandom_range(0, 3) == 0) ? near_value() : a + $signed(64'($urandom_range(0, 12)));
      if ($urandom_range(0, 15) != 0 && a > b) begin
         t = a;
         a = b;
         b = t;
      end
      sel = $urandom_range(0, 99);
      if (sel < 42) op = OP_ADD;
      else if (sel < 62) op = OP_SUB;
      else if (sel < 77) op = OP_INC;
      else if (sel < 95) op = OP_READ;
      else if (sel < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      send_item(op, a, b, 6'($urandom), no_gap);
   endtask

   initial begin
      table_model = new();
      table_model.clear_table();
      table_model.errors = 0;
      idle_cycles = 0;
      anchor = 64'sd0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every operation, limits, reversed ranges, bad index
      send_item(OP_READ, 64'sd0, 64'sd0, 6'd0, 0);
      send_item(OP_ADD, LlongMin, LlongMin + 64'sd5, 6'd0, 0);
      send_item(OP_ADD, LlongMax - 64'sd5, LlongMax, 6'd0, 0);
      send_item(OP_ADD, 64'sd10, 64'sd20, 6'd0, 0);
      send_item(OP_ADD, 64'sd21, 64'sd30, 6'd0, 1);
      send_item(OP_ADD, 64'sd40, 64'sd50, 6'd0, 0);
      send_item(OP_INC, 64'sd12, 64'sd29, 6'd0, 0);
      send_item(OP_INC, 64'sd25, 64'sd45, 6'd0, 0);
      send_item(OP_SUB, 64'sd15, 64'sd16, 6'd0, 0);
      send_item(OP_SUB, 64'sd9, 64'sd10, 6'd0, 1);
      send_item(OP_SUB, LlongMin, LlongMin, 6'd0, 0);
      send_item(OP_SUB, LlongMax, LlongMax, 6'd0, 0);
      send_item(OP_READ, 64'sd0, 64'sd0, 6'd1, 0);
      send_item(OP_READ, 64'sd0, 64'sd0, 6'd63, 0);
      send_item(OP_ADD, 64'sd5, 64'sd4, 6'd0, 0);
      send_item(OP_SUB, LlongMax, LlongMin, 6'd0, 0);
      send_item(OP_INC, 64'sd1, -64'sd1, 6'd0, 0);
      send_item(3'd5, -64'sd1, -64'sd1, 6'h3f, 0);
      send_item(3'd7, 64'sd0, 64'sd0, 6'd0, 0);
      send_item(OP_ADD, LlongMin, LlongMax, 6'd0, 0);
      send_item(OP_INC, LlongMin, LlongMax, 6'd0, 0);
      send_item(OP_SUB, 64'sd0, 64'sd0, 6'd0, 0);
      send_item(OP_READ, 64'sd0, 64'sd0, 6'd1, 0);
      send_item(OP_CLEAR, 64'sd0, 64'sd0, 6'd0, 0);

      // fill to capacity with isolated points, overflow on add, then split back to capacity
      for (int i = 0; i < TableDepth; i++)
         send_item(OP_ADD, 64'(i * 4), 64'(i * 4), 6'd0, 1);
      send_item(OP_ADD, 64'sd1000, 64'sd1000, 6'd0, 0);
      send_item(OP_READ, 64'sd0, 64'sd0, 6'd63, 0);
      send_item(OP_SUB, 64'sd0, 64'sd0, 6'd0, 0);
      send_item(OP_ADD, 64'sd2, 64'sd3, 6'd0, 0);
      send_item(OP_SUB, 64'sd3, 64'sd3, 6'd0, 0);
      send_item(OP_CLEAR, 64'sd0, 64'sd0, 6'd0, 0);

      for (int n = 0; n < RandomItems; n++) begin
         if ($urandom_range(0, 199) == 0) anchor = {$urandom, $urandom};
         else if ($urandom_range(0, 199) == 0) anchor = LlongMin;
         else if ($urandom_range(0, 199) == 0) anchor = LlongMax - 64'sd400;
         // alternate bursts with no gaps and gapped stretches
         random_item((n / 64) % 3 == 0);
      end
      start <= 1'b0;

      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (table_model.errors == 0 && table_model.pending.size() == 0)
         $display("sorted_interval_set_table_top: match");
      else
         $display("sorted_interval_set_table_top: mismatch");
      $finish;
   end

endmodule

// ----- sorted_interval_set_table_top.f -----
+incdir+rtl
rtl/sist_pkg.sv
rtl/sist_ram.sv
rtl/sist_front.sv
rtl/sist_back.sv
rtl/sorted_interval_set_table_top.sv
tb/sorted_interval_set_table_top_tb.sv
